// ===== sv/mkpa_pkg.sv =====
`timescale 1ns / 1ps

package mkpa_pkg;

  // Field widths of the two channels.
  localparam int unsigned ButtonsW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ActionW  = 3;

  // Priority map: seven slots of one pad bit index each.
  localparam int unsigned MapSlots        = 7;
  localparam int unsigned SlotIdxW        = 4;
  localparam int unsigned MapW            = MapSlots * SlotIdxW;
  localparam int unsigned NumPriorityKeys = 7;

  // Configuration port.
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 4;

  // Register reset values.
  localparam logic [TimeW-1:0] StartDelayRst    = 32'd500000;
  localparam logic [TimeW-1:0] ContinueDelayRst = 32'd100000;
  localparam logic [MapW-1:0]  KeyMapRst        = 28'd7685854;

  // Action code for "no key".
  localparam logic [ActionW-1:0] ActionNone = '0;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_START_DELAY    = 2'd0,
    REG_CONTINUE_DELAY = 2'd1,
    REG_KEY_MAP        = 2'd2
  } cfg_reg_idx_t;

  // Typematic phase of the held action.
  typedef enum logic [1:0] {
    PHASE_NOT_HELD = 2'd0,
    PHASE_INITIAL  = 2'd1,
    PHASE_REPEAT   = 2'd2
  } repeat_phase_t;

endpackage

// ===== sv/mkpa_in_if.sv =====
`timescale 1ns / 1ps

// Input channel: one pad sample with its timestamp per transfer.
interface mkpa_in_if;
  logic                               valid;
  logic                               ready;
  logic [mkpa_pkg::ButtonsW-1:0]      raw_buttons;
  logic [mkpa_pkg::TimeW-1:0]         timestamp;

  modport source (output valid, output raw_buttons, output timestamp, input ready);
  modport sink   (input valid, input raw_buttons, input timestamp, output ready);
endinterface

// ===== sv/mkpa_out_if.sv =====
`timescale 1ns / 1ps

// Result channel: one action code per transfer.
interface mkpa_out_if;
  logic                               valid;
  logic                               ready;
  logic [mkpa_pkg::ActionW-1:0]       action;

  modport source (output valid, output action, input ready);
  modport sink   (input valid, input action, output ready);
endinterface

// ===== sv/menu_key_priority_autorepeat_core.sv =====
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the decode, the
// 32-bit elapsed-time subtraction and the delay compare all sit between the
// input handshake and the single result register, loaded with the repeat state.
// Reset (rst_n low, synchronous) restores the default delays and key map,
// clears the repeat state and drops any pending result.
`timescale 1ns / 1ps

module menu_key_priority_autorepeat_core (
  input  logic                              clk,
  input  logic                              rst_n,
  mkpa_in_if.sink                           in_ch,
  mkpa_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mkpa_pkg::CfgAddrW-1:0]     paddr,
  input  logic [mkpa_pkg::CfgDataW-1:0]     pwdata,
  output logic [mkpa_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready
);

  // Configuration registers.
  logic [mkpa_pkg::TimeW-1:0] start_delay_r;
  logic [mkpa_pkg::TimeW-1:0] continue_delay_r;
  logic [mkpa_pkg::MapW-1:0]  key_map_r;

  // Repeat state.
  mkpa_pkg::repeat_phase_t       phase_r, phase_nxt;
  logic [mkpa_pkg::ActionW-1:0]  held_r, held_nxt;
  logic [mkpa_pkg::TimeW-1:0]    last_emit_r, last_emit_nxt;

  // Result register.
  logic                          out_valid_r;
  logic [mkpa_pkg::ActionW-1:0]  out_action_r, out_action_nxt;

  logic                          in_fire;
  logic                          cfg_write;
  mkpa_pkg::cfg_reg_idx_t        cfg_idx;
  logic [mkpa_pkg::ButtonsW-1:0] pressed;
  logic [mkpa_pkg::ActionW-1:0]  action_c;
  logic [mkpa_pkg::TimeW-1:0]    elapsed;
  logic [mkpa_pkg::TimeW-1:0]    needed;
  logic                          new_event;

  // The result register empties when taken, so a new transfer can land in
  // the same cycle as the old result leaves.
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.action = out_action_r;

  // APB side: no wait states, word registers decoded by paddr[3:2].
  assign pready    = 1'b1;
  assign cfg_idx   = mkpa_pkg::cfg_reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      mkpa_pkg::REG_START_DELAY:    prdata = start_delay_r;
      mkpa_pkg::REG_CONTINUE_DELAY: prdata = continue_delay_r;
      mkpa_pkg::REG_KEY_MAP:        prdata = mkpa_pkg::CfgDataW'(key_map_r);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r    <= mkpa_pkg::StartDelayRst;
      continue_delay_r <= mkpa_pkg::ContinueDelayRst;
      key_map_r        <= mkpa_pkg::KeyMapRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        mkpa_pkg::REG_START_DELAY:    start_delay_r    <= pwdata;
        mkpa_pkg::REG_CONTINUE_DELAY: continue_delay_r <= pwdata;
        mkpa_pkg::REG_KEY_MAP:        key_map_r        <= pwdata[mkpa_pkg::MapW-1:0];
        default: ;
      endcase
    end
  end

  // Priority encode: the lowest pressed slot wins, so scan from the bottom
  // of the priority order upward and let higher slots overwrite.
  always_comb begin
    pressed  = ~in_ch.raw_buttons;
    action_c = mkpa_pkg::ActionNone;
    for (int s = mkpa_pkg::NumPriorityKeys - 1; s >= 0; s--) begin
      if (pressed[key_map_r[s*mkpa_pkg::SlotIdxW +: mkpa_pkg::SlotIdxW]]) begin
        action_c = mkpa_pkg::ActionW'(s + 1);
      end
    end
  end

  // Typematic decision: a new, changed or released action is sent at once;
  // a held one only once its wrapped elapsed time reaches the delay.
  always_comb begin
    new_event = (action_c == mkpa_pkg::ActionNone) || (action_c != held_r) ||
                (phase_r == mkpa_pkg::PHASE_NOT_HELD);
    elapsed   = in_ch.timestamp - last_emit_r;
    needed    = (phase_r == mkpa_pkg::PHASE_INITIAL) ? start_delay_r : continue_delay_r;

    phase_nxt      = phase_r;
    held_nxt       = held_r;
    last_emit_nxt  = last_emit_r;
    out_action_nxt = mkpa_pkg::ActionNone;

    if (new_event) begin
      held_nxt       = action_c;
      last_emit_nxt  = in_ch.timestamp;
      phase_nxt      = (action_c != mkpa_pkg::ActionNone) ? mkpa_pkg::PHASE_INITIAL
                                                          : mkpa_pkg::PHASE_NOT_HELD;
      out_action_nxt = action_c;
    end else if (elapsed >= needed) begin
      last_emit_nxt  = in_ch.timestamp;
      phase_nxt      = mkpa_pkg::PHASE_REPEAT;
      out_action_nxt = action_c;
    end
  end

  // State and result update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mkpa_pkg::PHASE_NOT_HELD;
      held_r      <= mkpa_pkg::ActionNone;
      last_emit_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        held_r      <= held_nxt;
        last_emit_r <= last_emit_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_action_r <= out_action_nxt;
    end
  end

  // The not-held phase goes together with an empty held action.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mkpa_pkg::PHASE_NOT_HELD) == (held_r == mkpa_pkg::ActionNone))
    else $error("repeat phase and held action disagree");

  // Every input transfer leaves a result in the register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("input transfer produced no result");

  // A pending nonzero result is always the action currently held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r != mkpa_pkg::ActionNone)) |-> (out_action_r == held_r))
    else $error("emitted action differs from held action");

  // An emission restarts the repeat timer at the item's timestamp.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (out_action_nxt != mkpa_pkg::ActionNone)) |=>
      (last_emit_r == $past(in_ch.timestamp)))
    else $error("emit time not captured");

endmodule

// ===== dv/tb_menu_key_priority_autorepeat_core.sv =====
`timescale 1ns / 1ps

module tb_menu_key_priority_autorepeat_core;
  import mkpa_pkg::*;

  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned RandomPerPhase = 135;
  localparam int unsigned LongHold       = 250;
  localparam int unsigned HoldSpacing    = 350;

  // One pad sample as offered on the input channel.
  typedef struct packed {
    logic [ButtonsW-1:0] raw;
    logic [TimeW-1:0]    stamp;
  } pad_sample_t;

  // Receiver stall behavior.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  mkpa_in_if  in_ch ();
  mkpa_out_if out_ch ();

  menu_key_priority_autorepeat_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Configuration as the block should currently hold it.
  logic [TimeW-1:0]   start_delay;
  logic [TimeW-1:0]   continue_delay;
  logic [MapW-1:0]    key_map;

  // Typematic state of the predictor.
  repeat_phase_t      held_phase;
  logic [ActionW-1:0] held_act;
  logic [TimeW-1:0]   last_emit;

  pad_sample_t        pending_samples[$];
  logic [ActionW-1:0] expected_actions[$];
  logic [TimeW-1:0]   stamp_now;

  int unsigned        cycle_count;
  int unsigned        mismatches;
  int unsigned        rx_count;
  bit                 in_taken;
  logic [ActionW-1:0] exp_action;

  pad_sample_t        drive_sample;
  int unsigned        burst_left;
  int unsigned        gap_left;

  rx_mode_t           rx_mode;
  int unsigned        mode_left;
  int unsigned        hold_left;
  int unsigned        next_hold_at;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Priority encode: the first mapped pad bit that is pressed gives slot plus one.
  function automatic logic [ActionW-1:0] decode_action(input logic [ButtonsW-1:0] raw);
    logic [ButtonsW-1:0] pressed;
    logic [SlotIdxW-1:0] bit_idx;
    pressed = ~raw;
    for (int s = 0; s < NumPriorityKeys; s++) begin
      bit_idx = key_map[s*SlotIdxW +: SlotIdxW];
      if (pressed[bit_idx]) begin
        return ActionW'(s + 1);
      end
    end
    return ActionNone;
  endfunction

  // Advance the typematic state by one pad sample and return the action it emits.
  function automatic logic [ActionW-1:0] typematic_action(input logic [ButtonsW-1:0] raw,
                                                          input logic [TimeW-1:0] now);
    logic [ActionW-1:0] act;
    logic [TimeW-1:0]   elapsed;
    logic [TimeW-1:0]   needed;
    act = decode_action(raw);
    if (act == ActionNone || act != held_act || held_phase == PHASE_NOT_HELD) begin
      held_act   = act;
      last_emit  = now;
      held_phase = (act != ActionNone) ? PHASE_INITIAL : PHASE_NOT_HELD;
      return act;
    end
    elapsed = now - last_emit;
    needed  = (held_phase == PHASE_INITIAL) ? start_delay : continue_delay;
    if (elapsed < needed) begin
      return ActionNone;
    end
    last_emit  = now;
    held_phase = PHASE_REPEAT;
    return act;
  endfunction

  function automatic logic [CfgDataW-1:0] register_value(input cfg_reg_idx_t idx);
    case (idx)
      REG_START_DELAY:    return start_delay;
      REG_CONTINUE_DELAY: return continue_delay;
      REG_KEY_MAP:        return CfgDataW'(key_map);
      default:            return '0;
    endcase
  endfunction

  // Time step between samples, scaled to the current delays so that
  // repeats fall both just before and just after their deadline.
  function automatic logic [TimeW-1:0] random_step();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(0, continue_delay);
      2:       return $urandom_range(0, start_delay);
      3:       return continue_delay;
      4:       return start_delay;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_sample(input logic [ButtonsW-1:0] raw, input logic [TimeW-1:0] stamp);
    pad_sample_t s;
    s.raw   = raw;
    s.stamp = stamp;
    pending_samples.push_back(s);
  endtask

  // Read a register back over the configuration port and compare it.
  task automatic check_reg(input cfg_reg_idx_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== register_value(idx)) begin
      mismatches++;
      $display("%0t: register %s read mismatch: expected 0x%08h, actual 0x%08h",
               $time, idx.name(), register_value(idx), prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it in the predictor, then read it back.
  task automatic write_reg(input cfg_reg_idx_t idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_DELAY:    start_delay = value;
      REG_CONTINUE_DELAY: continue_delay = value;
      REG_KEY_MAP:        key_map = value[MapW-1:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic set_config(input logic [TimeW-1:0] sd, input logic [TimeW-1:0] cd,
                            input logic [CfgDataW-1:0] km);
    write_reg(REG_START_DELAY, sd);
    write_reg(REG_CONTINUE_DELAY, cd);
    write_reg(REG_KEY_MAP, km);
  endtask

  // Wait until every sample has gone in and every action has come out.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || expected_actions.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Random key sessions: mostly a mapped key held over many samples,
  // with releases, random pad words and stray samples mixed in.
  task automatic add_sessions(input int unsigned count);
    int unsigned         added;
    int unsigned         hold_len;
    int                  slot;
    logic [ButtonsW-1:0] pressed;
    logic [ButtonsW-1:0] raw;
    added = 0;
    while (added < count) begin
      case ($urandom_range(0, 5))
        0: raw = '1;
        1: raw = ButtonsW'($urandom());
        default: begin
          slot    = $urandom_range(0, NumPriorityKeys - 1);
          pressed = ButtonsW'(1) << key_map[slot*SlotIdxW +: SlotIdxW];
          if ($urandom_range(0, 2) == 0) begin
            pressed |= ButtonsW'($urandom());
          end
          raw = ~pressed;
        end
      endcase
      hold_len = $urandom_range(1, 25);
      if (hold_len > count - added) begin
        hold_len = count - added;
      end
      repeat (hold_len) begin
        stamp_now += random_step();
        push_sample(($urandom_range(0, 9) == 0) ? ButtonsW'($urandom()) : raw, stamp_now);
        added++;
      end
    end
  endtask

  // Sender: offers queued samples in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Keep offering the same sample until its transfer.
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (pending_samples.size() > 0) begin
      drive_sample = pending_samples.pop_front();
      in_ch.raw_buttons <= drive_sample.raw;
      in_ch.timestamp   <= drive_sample.stamp;
      in_ch.valid       <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: changes its stall mode now and then, and twice holds off
  // for a long stretch so the block backs up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_count >= next_hold_at) begin
      hold_left = LongHold;
      next_hold_at += HoldSpacing;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STREAM: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end else if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        rx_count++;
        if (expected_actions.size() == 0) begin
          mismatches++;
          $display("%0t: action transfer %0d with nothing expected", $time, out_ch.action);
        end else begin
          exp_action = expected_actions.pop_front();
          if (out_ch.action !== exp_action) begin
            mismatches++;
            $display("%0t: action mismatch: expected %0d, actual %0d",
                     $time, exp_action, out_ch.action);
          end
        end
      end
      if (in_taken) begin
        expected_actions.push_back(typematic_action(in_ch.raw_buttons, in_ch.timestamp));
      end
    end
  end

  initial begin
    logic [SlotIdxW-1:0] slot_bit;
    logic [CfgDataW-1:0] map_word;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.raw_buttons = '1;
    in_ch.timestamp   = '0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    start_delay       = StartDelayRst;
    continue_delay    = ContinueDelayRst;
    key_map           = KeyMapRst;
    held_phase        = PHASE_NOT_HELD;
    held_act          = ActionNone;
    last_emit         = '0;
    stamp_now         = '0;
    cycle_count       = 0;
    mismatches        = 0;
    rx_count          = 0;
    in_taken          = 1'b0;
    burst_left        = 0;
    gap_left          = 0;
    rx_mode           = RX_STREAM;
    mode_left         = 0;
    hold_left         = 0;
    next_hold_at      = 300;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers come out of reset with their default values.
    check_reg(REG_START_DELAY);
    check_reg(REG_CONTINUE_DELAY);
    check_reg(REG_KEY_MAP);

    // Directed samples under the default delays and key map.
    push_sample(16'hFFFF, 32'd0);
    push_sample(16'h0000, 32'd10);
    push_sample(16'h0000, 32'd20);
    push_sample(16'h0000, 32'd500010);
    push_sample(16'h0000, 32'd600009);
    push_sample(16'h0000, 32'd600010);
    // Each slot alone, lowest priority first, so every action code appears.
    for (int s = NumPriorityKeys - 1; s >= 0; s--) begin
      slot_bit = key_map[s*SlotIdxW +: SlotIdxW];
      push_sample(~(ButtonsW'(1) << slot_bit), 32'd700000 + 32'(NumPriorityKeys - s));
    end
    // Time going backwards makes a held key repeat at once.
    slot_bit = key_map[0 +: SlotIdxW];
    push_sample(~(ButtonsW'(1) << slot_bit), 32'd699990);
    // Hold across the wrap of the time counter, exactly at the start delay.
    slot_bit = key_map[5*SlotIdxW +: SlotIdxW];
    push_sample(16'hFFFF, 32'hFFFF_FFF0);
    push_sample(~(ButtonsW'(1) << slot_bit), 32'hFFFF_FFF0);
    push_sample(~(ButtonsW'(1) << slot_bit), 32'h0007_A110);
    // A pressed bit that no slot watches gives no action.
    push_sample(16'hFFFD, 32'hFFFF_FFFF);
    push_sample(16'h0001, 32'd100);
    wait_drained();

    // Zero delays: a held key repeats on every sample.
    set_config('0, '0, CfgDataW'(KeyMapRst));
    push_sample(16'h0000, 32'd5);
    push_sample(16'h0000, 32'd5);
    push_sample(16'h0000, 32'd5);
    push_sample(16'hFFFF, 32'd6);
    wait_drained();

    // Random phases, each under its own configuration.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(32'd100, 32'd30, CfgDataW'(KeyMapRst));
        1: set_config('0, '0, $urandom());
        // Every slot watches the same bit: the lowest slot, slot 0, always wins.
        2: set_config('1, '1, 32'hFFFF_FFFF);
        3: begin
          map_word = $urandom();
          set_config($urandom_range(1, 5000), $urandom_range(1, 2000), map_word);
        end
        4: set_config(32'd1, '1, 32'h0000_0000);
        default: set_config(StartDelayRst, ContinueDelayRst, CfgDataW'(KeyMapRst));
      endcase
      add_sessions(RandomPerPhase);
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mkpa_pkg.sv
sv/mkpa_in_if.sv
sv/mkpa_out_if.sv
sv/menu_key_priority_autorepeat_core.sv
dv/tb_menu_key_priority_autorepeat_core.sv
